// ----- design/spherical_to_cartesian_top_assert.svh -----
// Assertion macros shared by the spherical-to-Cartesian checker.
`ifndef SPHERICAL_TO_CARTESIAN_TOP_ASSERT_SVH
`define SPHERICAL_TO_CARTESIAN_TOP_ASSERT_SVH

// Implication checked in the same cycle.
`define STC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define STC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked after the delay given by the n argument.
`define STC_ASSERT_LAT(label, ante, cons, n, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ----- design/stc_pkg.sv -----
// Shared constants and tables for the spherical-to-Cartesian converter.
`timescale 1ns / 1ps
package stc_pkg;

  localparam int unsigned ANG_W   = 32;
  localparam int unsigned VEC_W   = 32;
  localparam int unsigned IN_W    = 16;
  localparam int unsigned COORD_W = 17;

  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 32'sd421657428;
  localparam logic signed [ANG_W-1:0] ANG_PI      = 32'sd843314857;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 17'sd65535;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -17'sd65535;

  function automatic logic signed [ANG_W-1:0] atan_q28(input int idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      0:       val = 32'sd210828714;
      1:       val = 32'sd124459457;
      2:       val = 32'sd65760959;
      3:       val = 32'sd33381290;
      4:       val = 32'sd16755422;
      5:       val = 32'sd8385879;
      6:       val = 32'sd4193963;
      7:       val = 32'sd2097109;
      8:       val = 32'sd1048571;
      9:       val = 32'sd524287;
      10:      val = 32'sd262144;
      11:      val = 32'sd131072;
      12:      val = 32'sd65536;
      13:      val = 32'sd32768;
      14:      val = 32'sd16384;
      15:      val = 32'sd8192;
      16:      val = 32'sd4096;
      17:      val = 32'sd2048;
      18:      val = 32'sd1024;
      19:      val = 32'sd512;
      20:      val = 32'sd256;
      21:      val = 32'sd128;
      22:      val = 32'sd64;
      23:      val = 32'sd32;
      default: val = '0;
    endcase
    return val;
  endfunction

  function automatic logic signed [VEC_W-1:0] inv_gain_q30(input int stages);
    logic signed [VEC_W-1:0] val;
    case (stages)
      8:       val = 32'sd652039507;
      9:       val = 32'sd652034532;
      10:      val = 32'sd652033289;
      11:      val = 32'sd652032978;
      12:      val = 32'sd652032900;
      13:      val = 32'sd652032881;
      14:      val = 32'sd652032876;
      default: val = 32'sd652032874;
    endcase
    return val;
  endfunction

endpackage

// ----- design/spherical_to_cartesian_top.sv -----
// Top level of the spherical-to-Cartesian converter.
`timescale 1ns / 1ps
// Converts (radius, polar angle, azimuth) items into Cartesian coordinates.
// Angles are signed Q2.13 radians; the radius is an unsigned integer.
// An item is taken at a rising edge where start_i is high and busy_o is low.
// Each result appears on x_coord_o, y_coord_o and z_coord_o for exactly one
// cycle, marked by valid_o, and must be taken in that cycle.
// The path holds one angle fold stage, one register per CORDIC stage, one sign stage
// and four multiplier stages. The two CORDIC pipelines run side by side.
// Throughput is one item per cycle; a new item may be started every cycle.
// busy_o is high during reset and for the first cycle after it, then stays
// low. Reset clears every item in flight. Results cannot be held off.
// Coordinates are rounded and saturate to the range -65535 to 65535.
module spherical_to_cartesian_top #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [stc_pkg::IN_W-1:0]            radius_i,
  input  logic signed [stc_pkg::IN_W-1:0]     polar_angle_i,
  input  logic signed [stc_pkg::IN_W-1:0]     azimuth_angle_i,
  output logic                                valid_o,
  output logic signed [stc_pkg::COORD_W-1:0]  x_coord_o,
  output logic signed [stc_pkg::COORD_W-1:0]  y_coord_o,
  output logic signed [stc_pkg::COORD_W-1:0]  z_coord_o
);

  localparam int unsigned CORDIC_LAT = CORDIC_STAGES + 2;

  logic                          busy_q;
  logic                          valid_q  [CORDIC_LAT];
  logic [stc_pkg::IN_W-1:0]      radius_q [CORDIC_LAT];

  logic signed [stc_pkg::VEC_W-1:0] cos_p;
  logic signed [stc_pkg::VEC_W-1:0] sin_p;
  logic signed [stc_pkg::VEC_W-1:0] cos_a;
  logic signed [stc_pkg::VEC_W-1:0] sin_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      for (int k = 0; k < CORDIC_LAT; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else begin
      busy_q     <= 1'b0;
      valid_q[0] <= start_i & ~busy_q;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    radius_q[0] <= radius_i;
    for (int k = 1; k < CORDIC_LAT; k++) begin
      radius_q[k] <= radius_q[k-1];
    end
  end

  assign busy_o = busy_q;

  stc_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic_polar (
    .clk_i (clk_i),
    .ang_i (polar_angle_i),
    .cos_o (cos_p),
    .sin_o (sin_p)
  );

  stc_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic_azimuth (
    .clk_i (clk_i),
    .ang_i (azimuth_angle_i),
    .cos_o (cos_a),
    .sin_o (sin_a)
  );

  stc_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_q[CORDIC_LAT-1]),
    .radius_i (radius_q[CORDIC_LAT-1]),
    .cos_p_i  (cos_p),
    .sin_p_i  (sin_p),
    .cos_a_i  (cos_a),
    .sin_a_i  (sin_a),
    .valid_o  (valid_o),
    .x_o      (x_coord_o),
    .y_o      (y_coord_o),
    .z_o      (z_coord_o)
  );

endmodule

// ----- design/stc_cordic.sv -----
// Pipelined rotation-mode CORDIC giving the cosine and sine of one Q2.13 angle.
`timescale 1ns / 1ps
module stc_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  logic                                 clk_i,
  input  logic signed [stc_pkg::IN_W-1:0]      ang_i,
  output logic signed [stc_pkg::VEC_W-1:0]     cos_o,
  output logic signed [stc_pkg::VEC_W-1:0]     sin_o
);

  localparam logic signed [stc_pkg::VEC_W-1:0] INV_GAIN = stc_pkg::inv_gain_q30(STAGES);

  logic signed [stc_pkg::VEC_W-1:0] x_q [STAGES+1];
  logic signed [stc_pkg::VEC_W-1:0] y_q [STAGES+1];
  logic signed [stc_pkg::ANG_W-1:0] z_q [STAGES];
  logic                             flip_q [STAGES+1];

  logic signed [stc_pkg::ANG_W-1:0] ang_wide;
  logic signed [stc_pkg::ANG_W-1:0] z_d;
  logic                             flip_d;

  always_comb begin
    ang_wide = stc_pkg::ANG_W'(ang_i) <<< 15;
    if (ang_wide > stc_pkg::ANG_HALF_PI) begin
      z_d    = ang_wide - stc_pkg::ANG_PI;
      flip_d = 1'b1;
    end else if (ang_wide < -stc_pkg::ANG_HALF_PI) begin
      z_d    = ang_wide + stc_pkg::ANG_PI;
      flip_d = 1'b1;
    end else begin
      z_d    = ang_wide;
      flip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= INV_GAIN;
    y_q[0]    <= '0;
    z_q[0]    <= z_d;
    flip_q[0] <= flip_d;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [stc_pkg::ANG_W-1:0] ATAN = stc_pkg::atan_q28(i);

    always_ff @(posedge clk_i) begin
      flip_q[i+1] <= flip_q[i];
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
      end
    end

    if (i < STAGES - 1) begin : g_angle
      always_ff @(posedge clk_i) begin
        if (z_q[i] >= 0) begin
          z_q[i+1] <= z_q[i] - ATAN;
        end else begin
          z_q[i+1] <= z_q[i] + ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (flip_q[STAGES]) begin
      cos_o <= -x_q[STAGES];
      sin_o <= -y_q[STAGES];
    end else begin
      cos_o <= x_q[STAGES];
      sin_o <= y_q[STAGES];
    end
  end

endmodule

// ----- design/stc_scale.sv -----
// Multiplier pipeline that scales the sines and cosines by the radius.
`timescale 1ns / 1ps
module stc_scale (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [stc_pkg::IN_W-1:0]             radius_i,
  input  logic signed [stc_pkg::VEC_W-1:0]     cos_p_i,
  input  logic signed [stc_pkg::VEC_W-1:0]     sin_p_i,
  input  logic signed [stc_pkg::VEC_W-1:0]     cos_a_i,
  input  logic signed [stc_pkg::VEC_W-1:0]     sin_a_i,
  output logic                                 valid_o,
  output logic signed [stc_pkg::COORD_W-1:0]   x_o,
  output logic signed [stc_pkg::COORD_W-1:0]   y_o,
  output logic signed [stc_pkg::COORD_W-1:0]   z_o
);

  localparam int unsigned PROD_W = stc_pkg::IN_W + 1 + stc_pkg::VEC_W;
  localparam int unsigned RS_W   = 33;
  localparam int unsigned PART_W = 17;
  localparam int unsigned PP_W   = PART_W + stc_pkg::VEC_W;
  localparam int unsigned SUM_W  = 66;
  localparam int unsigned ZR_W   = PROD_W - 30;
  localparam int unsigned XR_W   = SUM_W - 45;

  function automatic logic signed [stc_pkg::COORD_W-1:0] clamp_z(
    input logic signed [ZR_W-1:0] v
  );
    if (v > ZR_W'(stc_pkg::COORD_MAX)) return stc_pkg::COORD_MAX;
    if (v < ZR_W'(stc_pkg::COORD_MIN)) return stc_pkg::COORD_MIN;
    return v[stc_pkg::COORD_W-1:0];
  endfunction

  function automatic logic signed [stc_pkg::COORD_W-1:0] clamp_xy(
    input logic signed [XR_W-1:0] v
  );
    if (v > XR_W'(stc_pkg::COORD_MAX)) return stc_pkg::COORD_MAX;
    if (v < XR_W'(stc_pkg::COORD_MIN)) return stc_pkg::COORD_MIN;
    return v[stc_pkg::COORD_W-1:0];
  endfunction

  logic [3:0] valid_q;

  logic signed [PROD_W-1:0]          prod_rs_q;
  logic signed [PROD_W-1:0]          prod_z_q;
  logic signed [stc_pkg::VEC_W-1:0]  cos_a_q;
  logic signed [stc_pkg::VEC_W-1:0]  sin_a_q;

  logic signed [RS_W-1:0]            rs_q;
  logic signed [stc_pkg::VEC_W-1:0]  cos_b_q;
  logic signed [stc_pkg::VEC_W-1:0]  sin_b_q;
  logic signed [stc_pkg::COORD_W-1:0] z_b_q;

  logic signed [PP_W-1:0]            pp_xh_q;
  logic signed [PP_W-1:0]            pp_xl_q;
  logic signed [PP_W-1:0]            pp_yh_q;
  logic signed [PP_W-1:0]            pp_yl_q;
  logic signed [stc_pkg::COORD_W-1:0] z_c_q;

  logic signed [PART_W:0]            rad_s;
  logic signed [PROD_W-1:0]          rs_sum;
  logic signed [PROD_W-1:0]          z_sum;
  logic signed [PART_W-1:0]          rs_hi;
  logic signed [PART_W-1:0]          rs_lo;
  logic signed [SUM_W-1:0]           x_sum;
  logic signed [SUM_W-1:0]           y_sum;

  always_comb begin
    rad_s  = $signed({2'b00, radius_i});
    rs_sum = prod_rs_q + (PROD_W'(1) <<< 14);
    z_sum  = prod_z_q + (PROD_W'(1) <<< 29);
    rs_hi  = rs_q[RS_W-1:16];
    rs_lo  = $signed({1'b0, rs_q[15:0]});
    x_sum  = (SUM_W'(pp_xh_q) <<< 16) + SUM_W'(pp_xl_q) + (SUM_W'(1) <<< 44);
    y_sum  = (SUM_W'(pp_yh_q) <<< 16) + SUM_W'(pp_yl_q) + (SUM_W'(1) <<< 44);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_rs_q <= PROD_W'(rad_s) * PROD_W'(sin_p_i);
    prod_z_q  <= PROD_W'(rad_s) * PROD_W'(cos_p_i);
    cos_a_q   <= cos_a_i;
    sin_a_q   <= sin_a_i;

    rs_q    <= rs_sum[RS_W+14:15];
    cos_b_q <= cos_a_q;
    sin_b_q <= sin_a_q;
    z_b_q   <= clamp_z(z_sum[PROD_W-1:30]);

    pp_xh_q <= PP_W'(rs_hi) * PP_W'(cos_b_q);
    pp_xl_q <= PP_W'(rs_lo) * PP_W'(cos_b_q);
    pp_yh_q <= PP_W'(rs_hi) * PP_W'(sin_b_q);
    pp_yl_q <= PP_W'(rs_lo) * PP_W'(sin_b_q);
    z_c_q   <= z_b_q;

    x_o <= clamp_xy(x_sum[SUM_W-1:45]);
    y_o <= clamp_xy(y_sum[SUM_W-1:45]);
    z_o <= z_c_q;
  end

  assign valid_o = valid_q[3];

endmodule

// ----- design/stc_checker.sv -----
// Port-level checker for the spherical-to-Cartesian converter and its bind.
`timescale 1ns / 1ps
`include "spherical_to_cartesian_top_assert.svh"
module stc_checker #(
  parameter int unsigned LAT = 22
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic                                valid_o,
  input logic signed [stc_pkg::COORD_W-1:0]  x_coord_o,
  input logic signed [stc_pkg::COORD_W-1:0]  y_coord_o,
  input logic signed [stc_pkg::COORD_W-1:0]  z_coord_o
);

  logic accept;
  logic coords_in_range;

  assign accept = start_i && !busy_o;
  assign coords_in_range = (x_coord_o != 17'sh10000) && (y_coord_o != 17'sh10000) &&
                           (z_coord_o != 17'sh10000);

  `STC_ASSERT_LAT(a_item_yields_result, accept, valid_o, LAT, "item produced no result")
  `STC_ASSERT_NOW(a_result_has_item, valid_o, $past(accept, LAT), "result without an item")
  `STC_ASSERT_NOW(a_result_saturated, valid_o, coords_in_range, "coordinate out of range")
  `STC_ASSERT_NEXT(a_busy_stays_low, !busy_o, !busy_o, "busy rose after reset")

endmodule

bind spherical_to_cartesian_top stc_checker #(
  .LAT(CORDIC_STAGES + 6)
) u_stc_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the spherical-to-Cartesian converter.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned STAGES    = 16;
  localparam int          N_POINTS  = 1100;
  localparam int          CALM_TAIL = 150;
  localparam int          WD_LIMIT  = 2000;
  localparam int          ANG_LIM   = 25736;

  typedef struct {
    logic [stc_pkg::IN_W-1:0]        radius;
    logic signed [stc_pkg::IN_W-1:0] polar;
    logic signed [stc_pkg::IN_W-1:0] azimuth;
    bit                              hold;
  } point_t;

  typedef struct {
    logic signed [stc_pkg::COORD_W-1:0] x;
    logic signed [stc_pkg::COORD_W-1:0] y;
    logic signed [stc_pkg::COORD_W-1:0] z;
  } coord_t;

  localparam longint ATAN_Q28 [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32
  };

  localparam longint INV_GAIN_Q30 [17] = '{
    652039507, 652034532, 652033289, 652032978, 652032900, 652032881,
    652032876, 652032874, 652032874, 652032874, 652032874, 652032874,
    652032874, 652032874, 652032874, 652032874, 652032874
  };

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start_i = 1'b0;
  logic                               busy_o;
  logic [stc_pkg::IN_W-1:0]           radius_i = '0;
  logic signed [stc_pkg::IN_W-1:0]    polar_angle_i = '0;
  logic signed [stc_pkg::IN_W-1:0]    azimuth_angle_i = '0;
  logic                               valid_o;
  logic signed [stc_pkg::COORD_W-1:0] x_coord_o;
  logic signed [stc_pkg::COORD_W-1:0] y_coord_o;
  logic signed [stc_pkg::COORD_W-1:0] z_coord_o;

  point_t point_q[$];
  coord_t coord_q[$];
  int     mismatch_count = 0;
  int     checked_count = 0;
  int     directed_count = 0;
  int     wide_count = 0;
  int     gap_left = 0;
  int     idle_cycles = 0;

  spherical_to_cartesian_top #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .radius_i       (radius_i),
    .polar_angle_i  (polar_angle_i),
    .azimuth_angle_i(azimuth_angle_i),
    .valid_o        (valid_o),
    .x_coord_o      (x_coord_o),
    .y_coord_o      (y_coord_o),
    .z_coord_o      (z_coord_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_coord(input longint v);
    longint lim;
    lim = longint'(stc_pkg::COORD_MAX);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic cordic_sin_cos(input logic signed [stc_pkg::IN_W-1:0] ang,
                                output longint cos_q30, output longint sin_q30);
    longint z, x, y, nx;
    bit     flip;
    int     n, gidx;
    z = longint'(ang) * 32768;
    flip = 1'b0;
    if (z > longint'(stc_pkg::ANG_HALF_PI)) begin
      z = z - longint'(stc_pkg::ANG_PI);
      flip = 1'b1;
    end else if (z < -longint'(stc_pkg::ANG_HALF_PI)) begin
      z = z + longint'(stc_pkg::ANG_PI);
      flip = 1'b1;
    end
    n = (STAGES > 24) ? 24 : STAGES;
    gidx = int'(STAGES) - 8;
    if (gidx < 0) gidx = 0;
    if (gidx > 16) gidx = 16;
    x = INV_GAIN_Q30[gidx];
    y = 0;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_Q28[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_Q28[i];
      end
      x = nx;
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endtask

  task automatic convert_point(input point_t p, output coord_t c);
    longint r, cp, sp, ca, sa, rs;
    r = longint'({1'b0, p.radius});
    cordic_sin_cos(p.polar, cp, sp);
    cordic_sin_cos(p.azimuth, ca, sa);
    rs = round_shift(r * sp, 15);
    c.x = stc_pkg::COORD_W'(clamp_coord(round_shift(rs * ca, 45)));
    c.y = stc_pkg::COORD_W'(clamp_coord(round_shift(rs * sa, 45)));
    c.z = stc_pkg::COORD_W'(clamp_coord(round_shift(r * cp, 30)));
  endtask

  task automatic check_field(input string name, input logic signed [stc_pkg::COORD_W-1:0] want,
                             input logic signed [stc_pkg::COORD_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic add_point(input int r, input int p, input int a);
    point_t pt;
    pt.radius = r[stc_pkg::IN_W-1:0];
    pt.polar = p[stc_pkg::IN_W-1:0];
    pt.azimuth = a[stc_pkg::IN_W-1:0];
    pt.hold = 1'b0;
    if (p > ANG_LIM || p < -ANG_LIM || a > ANG_LIM || a < -ANG_LIM) wide_count++;
    point_q.push_back(pt);
  endtask

  function automatic int random_angle();
    if ($urandom_range(0, 19) == 0) return int'($signed(16'($urandom)));
    return int'($urandom_range(0, 2 * ANG_LIM)) - ANG_LIM;
  endfunction

  function automatic int random_radius();
    case ($urandom_range(0, 9))
      6, 7:    return $urandom_range(0, 255);
      8:       return 65535;
      9:       return $urandom_range(65000, 65535);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Driver: presents the next pending item and holds it until it is taken.
  always @(posedge clk_i) begin
    point_t p;
    coord_t c;
    bit     taken;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      taken = start_i && (busy_o === 1'b0);
      if (taken) begin
        p.radius = radius_i;
        p.polar = polar_angle_i;
        p.azimuth = azimuth_angle_i;
        p.hold = 1'b0;
        convert_point(p, c);
        coord_q.push_back(c);
      end
      if (!(start_i && !taken)) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (point_q.size() == 0 || (point_q[0].hold && coord_q.size() != 0)) begin
          start_i <= 1'b0;
        end else if (point_q.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 2);
          start_i <= 1'b0;
        end else begin
          p = point_q.pop_front();
          radius_i <= p.radius;
          polar_angle_i <= p.polar;
          azimuth_angle_i <= p.azimuth;
          start_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: results hold for one full cycle, so they are sampled mid-cycle.
  always @(negedge clk_i) begin
    coord_t c;
    if (rst_ni && valid_o) begin
      if (coord_q.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result with no item pending, expected none, got x=%0d y=%0d z=%0d",
                 $time, x_coord_o, y_coord_o, z_coord_o);
      end else begin
        c = coord_q.pop_front();
        checked_count++;
        check_field("x_coord", c.x, x_coord_o);
        check_field("y_coord", c.y, y_coord_o);
        check_field("z_coord", c.z, z_coord_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && busy_o === 1'b0) || valid_o === 1'b1) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WD_LIMIT) begin
        $display("tb_top: stalled for %0d cycles with %0d items pending", idle_cycles,
                 point_q.size());
        $display("tb_top: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    add_point(0, 0, 0);
    add_point(65535, 0, 0);
    add_point(65535, 12868, 0);
    add_point(65535, 12868, 12868);
    add_point(65535, -12868, -12868);
    add_point(65535, 12867, 12867);
    add_point(65535, -12867, -12867);
    add_point(65535, 25736, 25736);
    add_point(65535, -25736, -25736);
    add_point(65535, 25736, -25736);
    add_point(1, 12868, 6434);
    add_point(1, 6434, 6434);
    add_point(32768, 6434, -6434);
    add_point(1000, 12868, -12868);
    add_point(1000, -12868, 12868);
    add_point(0, -25736, 25736);
    add_point(65535, 32767, -32768);
    add_point(65535, -32768, 32767);
    add_point(43690, 21845, -21846);
    add_point(21845, -21846, 21845);
    add_point(65535, 25735, 1);
    directed_count = point_q.size();
    while (point_q.size() < N_POINTS) add_point(random_radius(), random_angle(), random_angle());
    point_q[400].hold = 1'b1;
    point_q[800].hold = 1'b1;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (point_q.size() != 0 || start_i || coord_q.size() != 0) @(negedge clk_i);
    repeat (STAGES + 16) @(negedge clk_i);

    $display("tb_top: %0d points converted and checked, %0d of them directed corner cases,",
             checked_count, directed_count);
    $display("tb_top: %0d points carried angle patterns beyond +-pi", wide_count);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- spherical_to_cartesian_top.f -----
+incdir+design
design/stc_pkg.sv
design/stc_cordic.sv
design/stc_scale.sv
design/spherical_to_cartesian_top.sv
design/stc_checker.sv
tb/tb_top.sv
